// ===== sv/nps_pkg.sv =====
package nps_pkg;

   // Field widths of the request and response transactions
   localparam int ACT_W   = 2;
   localparam int LAT_W   = 24;
   localparam int LON_W   = 25;
   localparam int STAT_W  = 2;
   localparam int NIDX_W  = 6;
   localparam int DIST_W  = 50;
   // Sum of two squares can reach one bit past the reported width
   localparam int SUM_W   = 51;

   // Action codes on req_action
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   // Status codes on rsp_status
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   // Decoded operation passed from the front end to the back end
   typedef enum logic [1:0] {
      OP_APPEND,
      OP_QUERY,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [LAT_W-1:0] lat;
      logic [LON_W-1:0] lon;
   } cmd_type;

endpackage

// ===== sv/nps_front.sv =====
module nps_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [nps_pkg::ACT_W-1:0]   req_action,
   input  logic signed [nps_pkg::LAT_W-1:0] req_point_lat,
   input  logic signed [nps_pkg::LON_W-1:0] req_point_lon,
   output logic                        push_valid,
   input  logic                        push_ready,
   output nps_pkg::cmd_type            push_data
);

   logic             front_v_ff;
   nps_pkg::cmd_type front_cmd_ff;
   nps_pkg::cmd_type cmd_in;

   // Decode the action code; the unused code becomes a no-op
   always_comb begin
      cmd_in.lat = req_point_lat;
      cmd_in.lon = req_point_lon;
      unique case (req_action)
         nps_pkg::ACT_APPEND: cmd_in.op = nps_pkg::OP_APPEND;
         nps_pkg::ACT_QUERY:  cmd_in.op = nps_pkg::OP_QUERY;
         nps_pkg::ACT_CLEAR:  cmd_in.op = nps_pkg::OP_CLEAR;
         default:             cmd_in.op = nps_pkg::OP_NOP;
      endcase
   end

   // Single holding stage in front of the command queue
   assign req_ready = !front_v_ff || push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (req_ready) begin
         front_v_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         front_cmd_ff <= cmd_in;
      end
   end

   assign push_valid = front_v_ff;
   assign push_data  = front_cmd_ff;

endmodule

// ===== sv/nps_queue.sv =====
module nps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  nps_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output nps_pkg::cmd_type pop_data
);

   nps_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Two-entry circular buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push_fire, pop_fire})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/nps_back.sv =====
module nps_back #(
   parameter int MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  nps_pkg::cmd_type              pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nps_pkg::STAT_W-1:0]    rsp_status,
   output logic [nps_pkg::NIDX_W-1:0]    rsp_nearest_index,
   output logic [nps_pkg::DIST_W-1:0]    rsp_nearest_dist_sq,
   output logic                          rsp_north_east
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);
   localparam int LAT_W = nps_pkg::LAT_W;
   localparam int LON_W = nps_pkg::LON_W;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              scan_idx_ff;
   logic [LAT_W-1:0]              q_lat_ff;
   logic [LON_W-1:0]              q_lon_ff;
   logic                          rsp_valid_ff;
   logic [nps_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [nps_pkg::NIDX_W-1:0]    rsp_index_ff;
   logic [nps_pkg::DIST_W-1:0]    rsp_dist_ff;
   logic                          rsp_ne_ff;

   // Point table
   logic [LAT_W-1:0]              lat_mem [MAX_POINTS];
   logic [LON_W-1:0]              lon_mem [MAX_POINTS];

   // Scan pipeline: read, difference, square, compare
   logic                          rd_v_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   logic [LAT_W-1:0]              rd_lat_ff;
   logic [LON_W-1:0]              rd_lon_ff;
   logic                          ab_v_ff;
   logic [IDX_W-1:0]              ab_idx_ff;
   logic [LAT_W-1:0]              abs_lat_ff;
   logic [LON_W-1:0]              abs_lon_ff;
   logic                          ab_ne_ff;
   logic                          sq_v_ff;
   logic [IDX_W-1:0]              sq_idx_ff;
   logic [2*LAT_W-1:0]            sq_lat_ff;
   logic [2*LON_W-1:0]            sq_lon_ff;
   logic                          sq_ne_ff;
   logic                          best_v_ff;
   logic [IDX_W-1:0]              best_idx_ff;
   logic [nps_pkg::SUM_W-1:0]     best_dist_ff;
   logic                          best_ne_ff;

   logic                          pop_fire;
   logic                          full;
   logic                          mem_we;
   logic                          scan_start;
   logic                          issue;
   logic                          scan_done;
   logic [IDX_W-1:0]              wr_addr;
   logic [IDX_W-1:0]              rd_addr;
   logic [LAT_W:0]                dlat_in;
   logic [LON_W:0]                dlon_in;
   logic [LAT_W:0]                dlat_neg;
   logic [LON_W:0]                dlon_neg;
   logic [LAT_W-1:0]              abs_lat_in;
   logic [LON_W-1:0]              abs_lon_in;
   logic                          ne_in;
   logic [nps_pkg::SUM_W-1:0]     sum_in;

   assign pop_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign pop_fire   = pop_valid && pop_ready;
   assign full       = (count_ff == FULL_COUNT);
   assign mem_we     = pop_fire && (pop_data.op == nps_pkg::OP_APPEND) && !full;
   assign scan_start = pop_fire && (pop_data.op == nps_pkg::OP_QUERY) && (count_ff != '0);
   assign issue      = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
   assign scan_done  = (state_ff == ST_SCAN) && !issue && !rd_v_ff && !ab_v_ff && !sq_v_ff;
   assign wr_addr    = count_ff[IDX_W-1:0];
   assign rd_addr    = scan_idx_ff[IDX_W-1:0];

   // Control sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_fire) begin
                  rsp_index_ff  <= '0;
                  rsp_dist_ff   <= '0;
                  rsp_ne_ff     <= 1'b0;
                  q_lat_ff      <= pop_data.lat;
                  q_lon_ff      <= pop_data.lon;
                  scan_idx_ff   <= '0;
                  unique case (pop_data.op)
                     nps_pkg::OP_APPEND: begin
                        rsp_valid_ff <= 1'b1;
                        if (full) begin
                           rsp_status_ff <= nps_pkg::STATUS_FULL;
                        end else begin
                           rsp_status_ff <= nps_pkg::STATUS_OK;
                           count_ff      <= count_ff + CNT_W'(1);
                        end
                     end
                     nps_pkg::OP_QUERY: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= nps_pkg::STATUS_EMPTY;
                        end else begin
                           rsp_status_ff <= nps_pkg::STATUS_OK;
                           state_ff      <= ST_SCAN;
                        end
                     end
                     nps_pkg::OP_CLEAR: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= nps_pkg::STATUS_OK;
                        count_ff      <= '0;
                     end
                     default: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= nps_pkg::STATUS_OK;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (issue) begin
                  scan_idx_ff <= scan_idx_ff + CNT_W'(1);
               end
               if (scan_done) begin
                  state_ff      <= ST_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= nps_pkg::STATUS_OK;
                  rsp_index_ff  <= nps_pkg::NIDX_W'(best_idx_ff);
                  rsp_dist_ff   <= best_dist_ff[nps_pkg::DIST_W-1:0];
                  rsp_ne_ff     <= best_ne_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Table write on append, registered read for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lat_mem[wr_addr] <= pop_data.lat;
         lon_mem[wr_addr] <= pop_data.lon;
      end
      rd_lat_ff <= lat_mem[rd_addr];
      rd_lon_ff <= lon_mem[rd_addr];
   end

   // Signed differences, magnitudes and the north-east test
   always_comb begin
      dlat_in    = {rd_lat_ff[LAT_W-1], rd_lat_ff} - {q_lat_ff[LAT_W-1], q_lat_ff};
      dlon_in    = {rd_lon_ff[LON_W-1], rd_lon_ff} - {q_lon_ff[LON_W-1], q_lon_ff};
      dlat_neg   = -dlat_in;
      dlon_neg   = -dlon_in;
      abs_lat_in = dlat_in[LAT_W] ? dlat_neg[LAT_W-1:0] : dlat_in[LAT_W-1:0];
      abs_lon_in = dlon_in[LON_W] ? dlon_neg[LON_W-1:0] : dlon_in[LON_W-1:0];
      ne_in      = !dlat_in[LAT_W] && !dlon_in[LON_W];
   end

   assign sum_in = nps_pkg::SUM_W'(sq_lat_ff) + nps_pkg::SUM_W'(sq_lon_ff);

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         ab_v_ff   <= 1'b0;
         sq_v_ff   <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= issue;
         ab_v_ff <= rd_v_ff;
         sq_v_ff <= ab_v_ff;
         if (scan_start) begin
            best_v_ff <= 1'b0;
         end else if (sq_v_ff) begin
            best_v_ff <= 1'b1;
         end
      end
   end

   // Pipeline payload; first strictly smaller distance wins
   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_addr;
      ab_idx_ff  <= rd_idx_ff;
      abs_lat_ff <= abs_lat_in;
      abs_lon_ff <= abs_lon_in;
      ab_ne_ff   <= ne_in;
      sq_idx_ff  <= ab_idx_ff;
      sq_lat_ff  <= abs_lat_ff * abs_lat_ff;
      sq_lon_ff  <= abs_lon_ff * abs_lon_ff;
      sq_ne_ff   <= ab_ne_ff;
      if (sq_v_ff && (!best_v_ff || (sum_in < best_dist_ff))) begin
         best_idx_ff  <= sq_idx_ff;
         best_dist_ff <= sum_in;
         best_ne_ff   <= sq_ne_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_nearest_index   = rsp_index_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;
   assign rsp_north_east      = rsp_ne_ff;

endmodule

// ===== sv/nearest_point_search_unit.sv =====
// Nearest point search unit.
// Request channel (req_valid/req_ready) carries an action and a point in
// signed Q.16 degrees: append the point, query the nearest stored point, or
// clear the table. Every request transaction yields one response transaction
// on rsp_valid/rsp_ready with a status, the index of the first nearest point,
// its squared distance in Q.32 and a north-east flag.
// Requests pass a decode register and a two-entry command queue; a back end
// executes one command at a time out of a point table with a write and a read port.
// Append, clear and a query on an empty table answer without a scan. A query
// with stored points reads the table one entry per cycle through a
// four-stage read/difference/square/compare pipeline, so the read port sets
// the rate. The back end takes its next command in the cycle after a
// response is accepted.
// While the receiver stalls, the response is held in the output register
// and up to three further requests are taken before req_ready drops.
// Reset empties the table and the queue; the table contents themselves are
// not cleared, only the point count.
module nearest_point_search_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [nps_pkg::ACT_W-1:0]          req_action,
   input  logic signed [nps_pkg::LAT_W-1:0]   req_point_lat,
   input  logic signed [nps_pkg::LON_W-1:0]   req_point_lon,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nps_pkg::STAT_W-1:0]         rsp_status,
   output logic [nps_pkg::NIDX_W-1:0]         rsp_nearest_index,
   output logic [nps_pkg::DIST_W-1:0]         rsp_nearest_dist_sq,
   output logic                               rsp_north_east
);

   logic             q_push_valid;
   logic             q_push_ready;
   nps_pkg::cmd_type q_push_data;
   logic             q_pop_valid;
   logic             q_pop_ready;
   nps_pkg::cmd_type q_pop_data;

   nps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_point_lat (req_point_lat),
      .req_point_lon (req_point_lon),
      .push_valid    (q_push_valid),
      .push_ready    (q_push_ready),
      .push_data     (q_push_data)
   );

   nps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   nps_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (q_pop_valid),
      .pop_ready           (q_pop_ready),
      .pop_data            (q_pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_nearest_dist_sq (rsp_nearest_dist_sq),
      .rsp_north_east      (rsp_north_east)
   );

   // Non-ok responses carry zero in every other field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != nps_pkg::STATUS_OK) |->
         (rsp_nearest_dist_sq == '0) && (rsp_nearest_index == '0) && !rsp_north_east)
      else $error("non-ok response with nonzero result fields");

   // Back end takes one command and is busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      q_pop_valid && q_pop_ready |=> !q_pop_ready)
      else $error("back end accepted two commands back to back");

   // Decode stage holds a command stalled by a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
      else $error("stalled command lost or changed in front of queue");

endmodule
